// ----- hw/rtl/bole_pkg.sv -----
// Shared types and codes for the bounded ordered list engine.
`default_nettype none

package bole_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int MAX_RESULTS  = 32;

	typedef logic [2:0] op_t;
	localparam op_t OP_INS_FRONT = 3'd0;
	localparam op_t OP_INS_REAR  = 3'd1;
	localparam op_t OP_DELETE    = 3'd2;
	localparam op_t OP_SEARCH    = 3'd3;
	localparam op_t OP_DUMP      = 3'd4;

	typedef logic [2:0] status_t;
	localparam status_t ST_OK       = 3'd0;
	localparam status_t ST_EMPTY    = 3'd1;
	localparam status_t ST_BADPOS   = 3'd2;
	localparam status_t ST_NOTFOUND = 3'd3;
	localparam status_t ST_FULL     = 3'd4;

	typedef logic signed [31:0] data_t;

	typedef logic [1:0] cell_cmd_t;
	localparam cell_cmd_t CMD_HOLD      = 2'd0;
	localparam cell_cmd_t CMD_LOAD      = 2'd1;
	localparam cell_cmd_t CMD_FROM_PREV = 2'd2;
	localparam cell_cmd_t CMD_FROM_NEXT = 2'd3;

endpackage

`default_nettype wire

// ----- hw/rtl/bole_cell.sv -----
// One list cell: holds an entry and moves it to or from its neighbors.
`default_nettype none

module bole_cell (
	input  wire logic               clk,
	input  wire bole_pkg::cell_cmd_t cmd,
	input  wire bole_pkg::data_t    load_val,
	input  wire bole_pkg::data_t    prev_val,
	input  wire bole_pkg::data_t    next_val,
	output bole_pkg::data_t         val
);
	import bole_pkg::*;

	data_t val_q;

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_HOLD:      val_q <= val_q;
			CMD_LOAD:      val_q <= load_val;
			CMD_FROM_PREV: val_q <= prev_val;
			CMD_FROM_NEXT: val_q <= next_val;
			default:       val_q <= val_q;
		endcase
	end

	assign val = val_q;

endmodule

`default_nettype wire

// ----- hw/rtl/bounded_ordered_list_engine_unit.sv -----
// Top level of the bounded ordered list engine: cell chain and sequencer.
// Inserts, deletes, no-op requests and searches or dumps of an empty list
// finish on acceptance; the result is registered and shows the cycle after acceptance.
// Search and dump rotate the whole cell chain once, pausing on output stalls;
// one dumped entry per cycle unless stalled. Next request after the rotation.
// Reset (arst_n low, asynchronous) empties the list and drops out_valid.
`default_nettype none

module bounded_ordered_list_engine_unit #(
	parameter int CAPACITY = bole_pkg::CAPACITY_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [2:0]         operation,
	input  wire logic signed [31:0] value,
	input  wire logic [5:0]         position,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [2:0]              status,
	output logic [5:0]              found_position,
	output logic signed [31:0]      entry_value,
	output logic [5:0]              entry_count,
	output logic                    last
);
	import bole_pkg::*;

	localparam int LEN_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_SCAN = 1'b1;

	logic             state_q;
	logic [LEN_W-1:0] len_q, len_d;
	logic [IDX_W-1:0] k_q;
	logic             dump_q;
	logic             found_q;
	logic [5:0]       fpos_q;
	data_t            key_q;
	logic             out_valid_q;

	data_t     cell_val [CAPACITY];
	cell_cmd_t cmd      [CAPACITY];

	logic    slot_free, accept, step, full, empty, in_list, hit, emit;
	status_t e_status;
	logic [5:0] e_pos;
	data_t   e_val;
	logic    e_last;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && slot_free;
	assign accept    = in_valid && in_ready;
	assign step      = (state_q == S_SCAN) && slot_free;
	assign full      = (len_q == LEN_W'(CAPACITY));
	assign empty     = (len_q == '0);
	assign in_list   = 32'(k_q) < 32'(len_q);
	assign hit       = in_list && (cell_val[0] == key_q) && !found_q;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		bole_cell u_cell (
			.clk      (clk),
			.cmd      (cmd[g]),
			.load_val (value),
			.prev_val ((g == 0) ? value : cell_val[(g == 0) ? 0 : g - 1]),
			.next_val (cell_val[(g + 1) % CAPACITY]),
			.val      (cell_val[g])
		);
	end

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			cmd[i] = CMD_HOLD;
		end
		len_d    = len_q;
		emit     = 1'b0;
		e_status = ST_OK;
		e_pos    = '0;
		e_val    = '0;
		e_last   = 1'b1;
		if (accept) begin
			emit = 1'b1;
			case (operation)
				OP_INS_FRONT: begin
					if (full) begin
						e_status = ST_FULL;
					end else begin
						for (int i = 0; i < CAPACITY; i++) begin
							cmd[i] = (i == 0) ? CMD_LOAD : CMD_FROM_PREV;
						end
						len_d = LEN_W'(len_q + 1'b1);
					end
				end
				OP_INS_REAR: begin
					if (full) begin
						e_status = ST_FULL;
					end else begin
						for (int i = 0; i < CAPACITY; i++) begin
							if (LEN_W'(i) == len_q) cmd[i] = CMD_LOAD;
						end
						len_d = LEN_W'(len_q + 1'b1);
					end
				end
				OP_DELETE: begin
					if (empty) begin
						e_status = ST_EMPTY;
					end else if (position == '0 || 32'(position) > 32'(len_q)) begin
						e_status = ST_BADPOS;
					end else begin
						for (int i = 0; i < CAPACITY; i++) begin
							if (32'(i) + 32'd1 >= 32'(position)) cmd[i] = CMD_FROM_NEXT;
						end
						len_d = LEN_W'(len_q - 1'b1);
					end
				end
				OP_SEARCH, OP_DUMP: begin
					if (empty) begin
						e_status = ST_EMPTY;
					end else begin
						emit = 1'b0;
					end
				end
				default: begin
					e_status = ST_OK;
				end
			endcase
		end else if (step) begin
			for (int i = 0; i < CAPACITY; i++) begin
				cmd[i] = CMD_FROM_NEXT;
			end
			if (dump_q) begin
				if (in_list && 32'(k_q) < MAX_RESULTS) begin
					emit   = 1'b1;
					e_pos  = 6'(32'(k_q) + 32'd1);
					e_val  = cell_val[0];
					e_last = (32'(k_q) + 32'd1 == 32'(len_q)) ||
						(32'(k_q) + 32'd1 == MAX_RESULTS);
				end
			end else if (k_q == IDX_W'(CAPACITY - 1)) begin
				emit = 1'b1;
				if (found_q) begin
					e_pos = fpos_q;
				end else if (hit) begin
					e_pos = 6'(32'(k_q) + 32'd1);
				end else begin
					e_status = ST_NOTFOUND;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			k_q         <= '0;
			dump_q      <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			len_q <= len_d;
			if (accept && (operation == OP_SEARCH || operation == OP_DUMP) && !empty) begin
				state_q <= S_SCAN;
				k_q     <= '0;
				found_q <= 1'b0;
				dump_q  <= (operation == OP_DUMP);
			end else if (step) begin
				k_q <= IDX_W'(k_q + 1'b1);
				if (hit) found_q <= 1'b1;
				if (k_q == IDX_W'(CAPACITY - 1)) state_q <= S_IDLE;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) key_q <= value;
		if (step && hit) fpos_q <= 6'(32'(k_q) + 32'd1);
		if (emit) begin
			status         <= e_status;
			found_position <= e_pos;
			entry_value    <= e_val;
			entry_count    <= 6'(len_d);
			last           <= e_last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for the bounded ordered list engine, checked against a mirrored list.
module tb;
	import bole_pkg::*;

	localparam int CAP = CAPACITY_DEF;

	typedef struct {
		status_t        status;
		logic [5:0]     found_position;
		data_t          entry_value;
		logic [5:0]     entry_count;
		logic           last;
	} list_result_t;

	class list_mirror;
		data_t          entries[CAP];
		int             length = 0;
		list_result_t   pending_results[$];
		int             errors = 0;

		function void expect_result(status_t st, int pos, data_t val, logic fin);
			list_result_t r;
			r.status = st;
			r.found_position = 6'(pos);
			r.entry_value = val;
			r.entry_count = 6'(length);
			r.last = fin;
			pending_results.push_back(r);
		endfunction

		function void note_request(op_t op, data_t val, logic [5:0] pos);
			int hit;
			int n;
			case (op)
			OP_INS_FRONT, OP_INS_REAR: begin
				if (length >= CAP) begin
					expect_result(ST_FULL, 0, 0, 1'b1);
					return;
				end
				if (op == OP_INS_FRONT) begin
					for (int i = length; i > 0; i--)
						entries[i] = entries[i - 1];
					entries[0] = val;
				end else begin
					entries[length] = val;
				end
				length++;
				expect_result(ST_OK, 0, 0, 1'b1);
			end
			OP_DELETE: begin
				if (length == 0) begin
					expect_result(ST_EMPTY, 0, 0, 1'b1);
					return;
				end
				if (pos < 1 || pos > length) begin
					expect_result(ST_BADPOS, 0, 0, 1'b1);
					return;
				end
				for (int i = pos - 1; i + 1 < length; i++)
					entries[i] = entries[i + 1];
				length--;
				expect_result(ST_OK, 0, 0, 1'b1);
			end
			OP_SEARCH: begin
				if (length == 0) begin
					expect_result(ST_EMPTY, 0, 0, 1'b1);
					return;
				end
				hit = 0;
				for (int i = 0; i < length && hit == 0; i++)
					if (entries[i] == val)
						hit = i + 1;
				if (hit != 0)
					expect_result(ST_OK, hit, 0, 1'b1);
				else
					expect_result(ST_NOTFOUND, 0, 0, 1'b1);
			end
			OP_DUMP: begin
				n = (length > MAX_RESULTS) ? MAX_RESULTS : length;
				if (n == 0)
					expect_result(ST_EMPTY, 0, 0, 1'b1);
				for (int i = 0; i < n; i++)
					expect_result(ST_OK, i + 1, entries[i], i + 1 == n);
			end
			default:
				expect_result(ST_OK, 0, 0, 1'b1);
			endcase
		endfunction

		function void compare_field(string field_name, logic signed [31:0] want,
			logic signed [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d",
					$time, field_name, want, got);
			end
		endfunction

		function void check_result(list_result_t got);
			list_result_t want;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, status %0d position %0d value %0d",
					$time, got.status, got.found_position, got.entry_value);
				return;
			end
			want = pending_results.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("found_position", want.found_position, got.found_position);
			compare_field("entry_value", want.entry_value, got.entry_value);
			compare_field("entry_count", want.entry_count, got.entry_count);
			compare_field("last", want.last, got.last);
		endfunction
	endclass

	logic           clk;
	logic           arst_n;
	logic           in_valid;
	logic           in_ready;
	logic [2:0]     operation;
	data_t          value;
	logic [5:0]     position;
	logic           out_valid;
	logic           out_ready;
	status_t        status;
	logic [5:0]     found_position;
	data_t          entry_value;
	logic [5:0]     entry_count;
	logic           last;

	int             snd_idle_pct;
	int             rcv_idle_pct;
	int             hold_requests;
	list_mirror     mirror;

	bounded_ordered_list_engine_unit #(
		.CAPACITY(CAP)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.value(value),
		.position(position),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.found_position(found_position),
		.entry_value(entry_value),
		.entry_count(entry_count),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("tb: FAIL");
		$finish;
	end

	initial begin
		list_result_t got;
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				got.status = status;
				got.found_position = found_position;
				got.entry_value = entry_value;
				got.entry_count = entry_count;
				got.last = last;
				mirror.check_result(got);
			end
			@(negedge clk);
			if (hold_requests != hold_seen) begin
				hold_seen = hold_requests;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready = 1'b0;
			end else begin
				out_ready = ($urandom_range(0, 99) >= rcv_idle_pct);
			end
		end
	end

	task automatic send_request(op_t op, data_t val, logic [5:0] pos);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		operation = op;
		value = val;
		position = pos;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		mirror.note_request(op, val, pos);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		while (mirror.pending_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic data_t pick_value();
		case ($urandom_range(0, 9))
		0, 1, 2, 3, 4: return data_t'($urandom_range(0, 7)) - 4;
		5: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
		default: return data_t'($urandom);
		endcase
	endfunction

	task automatic insert_random();
		send_request($urandom_range(0, 1) ? OP_INS_REAR : OP_INS_FRONT, pick_value(),
			6'($urandom));
	endtask

	task automatic run_phase(int count);
		int r;
		int ins_w;
		int del_w;
		// fill to capacity, overflow twice, then dump the full list
		while (mirror.length < CAP)
			insert_random();
		insert_random();
		insert_random();
		send_request(OP_DUMP, pick_value(), 6'($urandom));
		for (int k = 0; k < count; k++) begin
			if (k % 40 == 0) begin
				case ($urandom_range(0, 2))
				0: begin
					ins_w = 70;
					del_w = 10;
				end
				1: begin
					ins_w = 15;
					del_w = 60;
				end
				default: begin
					ins_w = 40;
					del_w = 30;
				end
				endcase
			end
			r = $urandom_range(0, 99);
			if (r < ins_w)
				insert_random();
			else if (r < ins_w + del_w)
				send_request(OP_DELETE, pick_value(),
					(mirror.length > 0 && $urandom_range(0, 4) != 0) ?
					6'($urandom_range(1, mirror.length)) : 6'($urandom));
			else if (r < 95)
				send_request(OP_SEARCH,
					(mirror.length > 0 && $urandom_range(0, 2) != 0) ?
					mirror.entries[$urandom_range(0, mirror.length - 1)] : pick_value(),
					6'($urandom));
			else if (r < 99)
				send_request(OP_DUMP, pick_value(), 6'($urandom));
			else
				send_request(op_t'($urandom_range(5, 7)), pick_value(), 6'($urandom));
		end
	endtask

	initial begin
		mirror = new;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_INS_FRONT;
		value = 0;
		position = 0;
		snd_idle_pct = 19;
		rcv_idle_pct = 83;
		hold_requests = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_request(OP_DUMP, 0, 0);
		send_request(OP_DELETE, 0, 6'd1);
		send_request(OP_SEARCH, 0, 0);
		send_request(OP_INS_FRONT, 32'sh7fffffff, 0);
		send_request(OP_INS_REAR, 32'sh80000000, 0);
		send_request(OP_INS_FRONT, 0, 0);
		send_request(OP_INS_REAR, -1, 0);
		send_request(OP_INS_FRONT, -1, 0);
		send_request(OP_SEARCH, -1, 0);
		send_request(OP_SEARCH, 32'sh80000000, 0);
		send_request(OP_SEARCH, 12345, 0);
		send_request(OP_DELETE, 0, 6'd0);
		send_request(OP_DELETE, 0, 6'd63);
		send_request(OP_DELETE, 0, 6'd6);
		send_request(OP_DELETE, 0, 6'd5);
		send_request(OP_DELETE, 0, 6'd1);
		send_request(OP_DELETE, 0, 6'd2);
		send_request(op_t'(5), -1, 6'h3f);
		send_request(op_t'(6), -1, 6'h3f);
		send_request(op_t'(7), -1, 6'h3f);
		send_request(OP_DUMP, 0, 0);
		send_request(OP_DELETE, 0, 6'd1);
		send_request(OP_DELETE, 0, 6'd1);
		send_request(OP_SEARCH, 32'sh7fffffff, 0);

		run_phase(80);
		wait_drained();
		snd_idle_pct = 83;
		rcv_idle_pct = 19;
		run_phase(80);
		wait_drained();
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		// long output hold-off while the fill burst keeps coming
		hold_requests++;
		run_phase(80);
		wait_drained();
		repeat (2 * CAP + 20) @(posedge clk);
		if (mirror.errors == 0 && mirror.pending_results.size() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end
endmodule

// ----- bounded_ordered_list_engine_unit.f -----
hw/rtl/bole_pkg.sv
hw/rtl/bole_cell.sv
hw/rtl/bounded_ordered_list_engine_unit.sv
tb/tb.sv
